// File: sv/battery_level_monitor_core_assert.svh
// Assertion macros shared by the battery level monitor RTL.
`ifndef BATTERY_LEVEL_MONITOR_CORE_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/blm_pkg.sv
// Types, constants and the sample scaling function of the battery level monitor.
`default_nettype none

package blm_pkg;

    localparam int MV_W     = 14;
    localparam int RAW_W    = 12;
    localparam int MARGIN_W = 10;
    localparam int RUN_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MV_W-1:0]     POWEROFF_RST  = 14'd3550;
    localparam logic [MARGIN_W-1:0] MARGIN_RST    = 10'd100;
    localparam logic [MV_W-1:0]     FULL_RST      = 14'd4500;
    localparam logic [MV_W-1:0]     LEVEL_RST     = 14'd4150;
    localparam logic [MV_W-1:0]     HELD_UNSEEDED = 14'd1;
    localparam logic [RAW_W-1:0]    SCALE_MUL     = 12'd2500;
    localparam logic [RAW_W-1:0]    RAW_TIMEOUT   = 12'd0;

    localparam logic [RUN_W-1:0] RUN_ZERO = 2'd0;
    localparam logic [RUN_W-1:0] RUN_ONE  = 2'd1;
    localparam logic [RUN_W-1:0] RUN_MAX  = 2'd3;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_REPORT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POWEROFF_MV   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MARGIN_MV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MV       = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [RAW_W-1:0] raw_sample;
        logic             usb_present;
        logic             otg_present;
    } blm_in_t;

    typedef struct packed {
        logic [MV_W-1:0] level_mv;
        logic            charging;
        logic            poweroff_request;
        logic            low_led;
    } blm_out_t;

    typedef struct packed {
        logic [MV_W-1:0]     poweroff_mv;
        logic [MARGIN_W-1:0] led_margin_mv;
        logic [MV_W-1:0]     full_mv;
    } blm_cfg_t;

    typedef struct packed {
        logic [MV_W-1:0]  level;
        logic [MV_W-1:0]  held;
        logic             usb_last;
        logic [RUN_W-1:0] low_run;
        logic             led_state;
    } blm_state_t;

    // Millivolts are ((raw * 2500) >> 12) * 4: keep the top twelve bits, append two zeros.
    function automatic logic [MV_W-1:0] scale_sample(input logic [RAW_W-1:0] raw);
        logic [2*RAW_W-1:0] prod;
        prod = {{RAW_W{1'b0}}, raw} * {{RAW_W{1'b0}}, SCALE_MUL};
        return {prod[2*RAW_W-1:RAW_W], 2'b00};
    endfunction

endpackage

`default_nettype wire

// File: sv/blm_step.sv
// Next-state and result logic for one battery monitor word.
`default_nettype none

module blm_step (
    input  var blm_pkg::blm_in_t    in_word,
    input  var blm_pkg::blm_cfg_t   cfg,
    input  var blm_pkg::blm_state_t cur,
    output blm_pkg::blm_state_t     nxt,
    output blm_pkg::blm_out_t       res
);
    import blm_pkg::*;

    logic [MV_W-1:0] scaled;
    logic            raw_ok;
    logic [MV_W:0]   led_limit;

    assign scaled    = scale_sample(in_word.raw_sample);
    assign raw_ok    = (in_word.raw_sample != RAW_TIMEOUT);
    assign led_limit = {1'b0, cfg.poweroff_mv} + {{(MV_W + 1 - MARGIN_W){1'b0}}, cfg.led_margin_mv};

    always_comb begin
        logic [MV_W-1:0]  lvl;
        logic [MV_W-1:0]  mv;
        logic [RUN_W-1:0] run;
        nxt = cur;
        res = '0;
        lvl = cur.level;
        mv  = cur.level;
        run = cur.low_run;
        if (in_word.mode == MODE_TICK) begin
            if (raw_ok) begin
                lvl = scaled;
            end
            nxt.level = lvl;
            if (cur.held == HELD_UNSEEDED) begin
                nxt.held = lvl;
            end
            if (lvl < cfg.poweroff_mv) begin
                if (cur.low_run != RUN_MAX) begin
                    run = cur.low_run + RUN_ONE;
                end
                res.poweroff_request = (run > RUN_ONE) && !in_word.otg_present;
            end else begin
                run           = RUN_ZERO;
                nxt.led_state = ({1'b0, lvl} < led_limit);
            end
            nxt.low_run  = run;
            res.level_mv = lvl;
            res.low_led  = nxt.led_state;
        end else begin
            // A detach edge with a good sample refreshes the level before the hold logic.
            if (in_word.usb_present != cur.usb_last) begin
                if (!in_word.usb_present && raw_ok) begin
                    mv        = scaled;
                    nxt.level = scaled;
                end
                nxt.usb_last = in_word.usb_present;
            end
            if (in_word.usb_present) begin
                if (mv > cur.held) begin
                    nxt.held = mv;
                end else begin
                    mv = cur.held;
                end
                res.charging = 1'b1;
            end else begin
                if (mv > cur.held) begin
                    mv = cur.held;
                end else begin
                    nxt.held = mv;
                end
                if (mv > cfg.full_mv) begin
                    mv = cfg.full_mv;
                end
            end
            res.level_mv = mv;
            res.low_led  = cur.led_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/battery_level_monitor_core.sv
// Path: an accepted input word is held in the input register, then its result is loaded into the result register.
// Throughput: one word per cycle; the input register refills in the cycle the result
// register is loaded, so the only limit is the downstream m_ready.
// Configuration writes are taken in every cycle and act on the next word processed.
// Reset is synchronous and active low: it empties both registers and returns the
// level, hold, run count, LED and configuration registers to their defaults.
`default_nettype none

module battery_level_monitor_core (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  var blm_pkg::blm_in_t          s_data,
    output logic                          m_valid,
    input  wire                           m_ready,
    output blm_pkg::blm_out_t             m_data,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [blm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [blm_pkg::MV_W-1:0]       cfg_data
);
    import blm_pkg::*;

    logic       in_valid_reg;
    blm_in_t    in_data_reg;
    logic       out_valid_reg;
    blm_out_t   out_data_reg;
    blm_state_t state_reg;
    blm_state_t state_next;
    blm_cfg_t   cfg_reg;
    blm_out_t   res_next;
    logic       proc_fire;

    // The held word moves on whenever the result register is empty or being read.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    blm_step u_step (
        .in_word (in_data_reg),
        .cfg     (cfg_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (proc_fire) begin
            out_data_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.level     <= LEVEL_RST;
            state_reg.held      <= HELD_UNSEEDED;
            state_reg.usb_last  <= 1'b0;
            state_reg.low_run   <= RUN_ZERO;
            state_reg.led_state <= 1'b0;
        end else if (proc_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poweroff_mv   <= POWEROFF_RST;
            cfg_reg.led_margin_mv <= MARGIN_RST;
            cfg_reg.full_mv       <= FULL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_POWEROFF_MV:   cfg_reg.poweroff_mv   <= cfg_data;
                CFG_LED_MARGIN_MV: cfg_reg.led_margin_mv <= cfg_data[MARGIN_W-1:0];
                CFG_FULL_MV:       cfg_reg.full_mv       <= cfg_data;
                default: begin
                end
            endcase
        end
    end

`include "battery_level_monitor_core_assert.svh"

    `BLM_ASSERT_NEXT(a_result_follows, proc_fire, out_valid_reg,
        "processed word did not reach the result register")
    `BLM_ASSERT_SAME(a_poweroff_run, out_valid_reg && out_data_reg.poweroff_request,
        state_reg.low_run > RUN_ONE, "power-off requested without a run of low readings")
    `BLM_ASSERT_SAME(a_led_matches, out_valid_reg,
        out_data_reg.low_led == state_reg.led_state, "LED in result disagrees with LED state")
    `BLM_ASSERT_NEXT(a_held_seeded, proc_fire && in_data_reg.mode == MODE_TICK,
        state_reg.held != HELD_UNSEEDED, "held value still unseeded after a tick")

endmodule

`default_nettype wire

// File: test/battery_level_monitor_core_tb.sv
// Self-checking testbench for the battery level monitor: directed table, then random words.
`timescale 1ns / 1ps

module battery_level_monitor_core_tb;
    import blm_pkg::*;

    localparam int                   WATCHDOG_CYCLES = 1000;
    localparam int                   HOLD_CYCLES     = 60;
    localparam int                   PHASE_WORDS     = 185;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE       = 2'd3;
    localparam int                   MV_TOP          = 9996;

    typedef struct {
        blm_in_t  w;
        bit       typed;
        blm_out_t r;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    blm_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    blm_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MV_W-1:0]      cfg_data;

    battery_level_monitor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Predicted state of the monitor and its thresholds.
    blm_cfg_t         limits;
    logic [MV_W-1:0]  lvl;
    logic [MV_W-1:0]  held;
    logic             usb_seen;
    logic [RUN_W-1:0] run;
    logic             led;

    blm_out_t readings_q[$];
    blm_out_t want;
    int       errors = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       hold_tag = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    logic     usb_now = 1'b0;
    dir_row_t dir_rows[$];

    function automatic logic [MV_W-1:0] to_mv(input logic [RAW_W-1:0] raw);
        int unsigned p;
        p = raw * 32'd2500;
        return MV_W'((p >> 12) * 4);
    endfunction

    // Advances the predicted state by one input word and returns the word it reports.
    function automatic blm_out_t next_reading(input blm_in_t w);
        blm_out_t        r;
        logic [MV_W-1:0] mv;
        r = '0;
        if (w.mode == MODE_TICK) begin
            if (w.raw_sample != RAW_TIMEOUT)
                lvl = to_mv(w.raw_sample);
            if (held == HELD_UNSEEDED)
                held = lvl;
            if (lvl < limits.poweroff_mv) begin
                if (run != RUN_MAX)
                    run = run + RUN_ONE;
                r.poweroff_request = (run > RUN_ONE) && !w.otg_present;
            end else begin
                run = RUN_ZERO;
                led = ({1'b0, lvl} < ({1'b0, limits.poweroff_mv} + 15'(limits.led_margin_mv)));
            end
            mv = lvl;
        end else begin
            mv = lvl;
            if (w.usb_present != usb_seen) begin
                // Only a detach with a fresh sample rescales the level.
                if (!w.usb_present && w.raw_sample != RAW_TIMEOUT) begin
                    mv  = to_mv(w.raw_sample);
                    lvl = mv;
                end
                usb_seen = w.usb_present;
            end
            if (w.usb_present) begin
                if (mv > held)
                    held = mv;
                else
                    mv = held;
                r.charging = 1'b1;
            end else begin
                if (mv > held)
                    mv = held;
                else
                    held = mv;
                if (mv > limits.full_mv)
                    mv = limits.full_mv;
            end
        end
        r.level_mv = mv;
        r.low_led  = led;
        return r;
    endfunction

    function automatic dir_row_t row(input logic m, input int raw, input logic u, input logic o,
                                     input bit t, input int mv, input logic c, input logic p,
                                     input logic l);
        dir_row_t d;
        d.w     = '{mode: m, raw_sample: RAW_W'(raw), usb_present: u, otg_present: o};
        d.typed = t;
        d.r     = '{level_mv: MV_W'(mv), charging: c, poweroff_request: p, low_led: l};
        return d;
    endfunction

    function automatic blm_in_t random_word(input int band);
        blm_in_t w;
        int      t;
        int      r;
        int      pick;
        case (band)
            0: t = $urandom_range(int'(limits.poweroff_mv));
            1: t = int'(limits.poweroff_mv) + $urandom_range(int'(limits.led_margin_mv));
            2: t = $urandom_range(int'(limits.poweroff_mv) + int'(limits.led_margin_mv), MV_TOP);
            default: t = $urandom_range(MV_TOP);
        endcase
        r = (t * 4096) / 10000 + int'($urandom_range(6)) - 3;
        if (r < 1)
            r = 1;
        if (r > 4095)
            r = 4095;
        pick = $urandom_range(99);
        if (pick < 8)
            r = int'(RAW_TIMEOUT);
        else if (pick < 11)
            r = 4095;
        else if (pick < 14)
            r = 1;
        else if (band == 3)
            r = $urandom_range(4095);
        if ($urandom_range(99) < 15)
            usb_now = ~usb_now;
        w.mode        = ($urandom_range(99) < 60) ? MODE_TICK : MODE_REPORT;
        w.raw_sample  = RAW_W'(r);
        w.usb_present = usb_now;
        w.otg_present = ($urandom_range(99) < 25);
        return w;
    endfunction

    task automatic send_word(input blm_in_t w, input bit typed, input blm_out_t typed_r);
        blm_out_t pr;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pr = next_reading(w);
        readings_q.push_back(typed ? typed_r : pr);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (readings_q.size() != 0)
            @(posedge aclk);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [MV_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_POWEROFF_MV:   limits.poweroff_mv   = val;
            CFG_LED_MARGIN_MV: limits.led_margin_mv = val[MARGIN_W-1:0];
            CFG_FULL_MV:       limits.full_mv       = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int poff, input int margin_word, input int full);
        write_cfg(CFG_POWEROFF_MV, MV_W'(poff));
        write_cfg(CFG_LED_MARGIN_MV, MV_W'(margin_word));
        write_cfg(CFG_FULL_MV, MV_W'(full));
        write_cfg(CFG_SPARE, MV_W'($urandom));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(negedge aclk) begin
        if (hold_tag != hold_seen) begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (readings_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: word with nothing expected: got %p", m_data);
            end else begin
                want = readings_q.pop_front();
                if (m_data.level_mv !== want.level_mv || m_data.charging !== want.charging
                    || m_data.poweroff_request !== want.poweroff_request
                    || m_data.low_led !== want.low_led) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int band;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_POWEROFF_MV;
        cfg_data  = '0;
        limits    = '{poweroff_mv: POWEROFF_RST, led_margin_mv: MARGIN_RST, full_mv: FULL_RST};
        lvl       = LEVEL_RST;
        held      = HELD_UNSEEDED;
        usb_seen  = 1'b0;
        run       = RUN_ZERO;
        led       = 1'b0;
        band      = 3;

        dir_rows = '{
            // Report before the first tick compares against the unseeded hold.
            row(MODE_REPORT, 0,    0, 0, 1, 1,    0, 0, 0),
            row(MODE_TICK,   0,    0, 0, 1, 4150, 0, 0, 0),
            row(MODE_REPORT, 0,    0, 0, 1, 4150, 0, 0, 0),
            row(MODE_TICK,   4095, 1, 1, 1, 9996, 0, 0, 0),
            row(MODE_REPORT, 4095, 1, 1, 1, 9996, 1, 0, 0),
            row(MODE_REPORT, 0,    1, 0, 1, 9996, 1, 0, 0),
            // Detach with a timed-out sample keeps the level; on battery it is clamped.
            row(MODE_REPORT, 0,    0, 0, 1, 4500, 0, 0, 0),
            row(MODE_REPORT, 5,    1, 0, 1, 9996, 1, 0, 0),
            row(MODE_REPORT, 1,    0, 0, 1, 0,    0, 0, 0),
            row(MODE_TICK,   0,    0, 0, 1, 0,    0, 0, 0),
            row(MODE_TICK,   0,    0, 1, 1, 0,    0, 0, 0),
            row(MODE_TICK,   0,    0, 0, 1, 0,    0, 1, 0),
            row(MODE_TICK,   0,    0, 0, 1, 0,    0, 1, 0),
            row(MODE_TICK,   1475, 0, 0, 1, 3600, 0, 0, 1),
            row(MODE_TICK,   1000, 0, 0, 1, 2440, 0, 0, 1),
            row(MODE_TICK,   1000, 0, 0, 1, 2440, 0, 1, 1),
            row(MODE_REPORT, 0,    0, 0, 1, 0,    0, 0, 1),
            row(MODE_TICK,   'hAAA, 1, 1, 0, 0,   0, 0, 0),
            row(MODE_TICK,   'h555, 0, 0, 0, 0,   0, 0, 0),
            row(MODE_REPORT, 'h555, 1, 1, 0, 0,   0, 0, 0),
            row(MODE_REPORT, 'hAAA, 0, 0, 0, 0,   0, 0, 0)
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    apply_settings(3400, 200, 4200);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    apply_settings(0, 0, 0);
                    idle_pct  = 60;
                    stall_pct = 0;
                end
                2: begin
                    // Upper data bits above the margin field are dropped by the register.
                    apply_settings(MV_TOP, 16'h3FFF, MV_TOP);
                    idle_pct  = 0;
                    stall_pct = 60;
                end
                default: begin
                    apply_settings($urandom_range(3000, 4200), $urandom_range(1023),
                                   $urandom_range(3000, MV_TOP));
                    idle_pct  = 20;
                    stall_pct = 20;
                end
            endcase
            usb_now = usb_seen;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (i % 12 == 0)
                    band = $urandom_range(3);
                if (p == 0 && i == 90)
                    hold_tag++;
                if (p == 1 && i == 90)
                    drain();
                send_word(random_word(band), 0, '0);
            end
            drain();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (8) @(posedge aclk);
        if (errors == 0 && readings_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: battery_level_monitor_core.f
+incdir+sv
sv/blm_pkg.sv
sv/blm_step.sv
sv/battery_level_monitor_core.sv
test/battery_level_monitor_core_tb.sv
